// File: design/rx_duty_cycle_power_saver_unit_assert.svh
// Assertion macros for the receiver duty-cycle power saver.
// No dependencies; included by the modules that check their own logic.
`ifndef RX_DUTY_CYCLE_POWER_SAVER_UNIT_ASSERT_SVH
`define RX_DUTY_CYCLE_POWER_SAVER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked at every rising edge, muted while the reset is high.
`define RXDC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every rising edge, reset included.
`define RXDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RXDC_ASSERT(lbl, clk, rst, prop, msg)
`define RXDC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: design/rxdc_pkg.sv
// Types, codes and timing tables for the receiver duty-cycle power saver.
// No dependencies; imported by every module of the block.
package rxdc_pkg;

   localparam int unsigned PhaseW    = 2;
   localparam int unsigned TimeW     = 32;
   localparam int unsigned LevelW    = 3;
   localparam int unsigned DeltaW    = 17;

   // Phase codes
   localparam logic [PhaseW-1:0] PH_INACTIVE = 2'd0;
   localparam logic [PhaseW-1:0] PH_ENTRY    = 2'd1;
   localparam logic [PhaseW-1:0] PH_RX_ON    = 2'd2;
   localparam logic [PhaseW-1:0] PH_RX_OFF   = 2'd3;

   // Power commands
   localparam logic [1:0] PC_NONE       = 2'd0;
   localparam logic [1:0] PC_UP_ALL     = 2'd1;
   localparam logic [1:0] PC_DOWN_RX    = 2'd2;
   localparam logic [1:0] PC_DOWN_RX_BB = 2'd3;

   // Request kinds
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_FORCE = 1'b1;

   // Register indexes
   localparam logic CSR_SAVE_LEVEL   = 1'b0;
   localparam logic CSR_HOTSPOT_MODE = 1'b1;

   localparam logic [LevelW-1:0] LevelMax = 3'd5;
   localparam logic [LevelW-1:0] LevelReset = 3'd1;

   // Timing constants, 0.1 ms units
   localparam int unsigned RxBase        = 180;
   localparam int unsigned RxStep        = 20;
   localparam int unsigned RxScale       = 10;
   localparam int unsigned WaitBase      = 12;
   localparam int unsigned WaitStep      = 2;
   localparam int unsigned WaitScale     = 1000 * 10;
   localparam int unsigned MaxShiftLevel = 4;

   typedef struct packed {
      logic              req_type;
      logic [TimeW-1:0]  now_ticks;
      logic              has_signal;
      logic              scan_stepping;
      logic              user_event;
      logic              melody_playing;
      logic              prompt_playing;
      logic [PhaseW-1:0] new_phase;
   } rxdc_req_type;

   typedef struct packed {
      logic              rx_on;
      logic [1:0]        power_cmd;
      logic              beep_fix;
      logic              audio_if_disable;
      logic              audio_if_reset;
      logic [PhaseW-1:0] phase;
   } rxdc_rsp_type;

   typedef struct packed {
      logic [LevelW-1:0] save_level;
      logic              hotspot_mode;
   } rxdc_cfg_type;

   typedef struct packed {
      logic [PhaseW-1:0] phase;
      logic [TimeW-1:0]  deadline;
   } rxdc_state_type;

   // Receiver on time for a saturated level 1..5
   function automatic logic [DeltaW-1:0] rx_time(input logic [LevelW-1:0] lv);
      int unsigned t;
      t = (RxBase - RxStep * int'(lv)) * RxScale;
      return DeltaW'(t);
   endfunction

   // Receiver off time: on time doubled per level, capped at level four
   function automatic logic [DeltaW-1:0] off_time(input logic [LevelW-1:0] lv);
      logic [1:0] sh;
      if (lv == 3'd0) begin
         sh = 2'd0;
      end else if (int'(lv) >= MaxShiftLevel) begin
         sh = 2'(MaxShiftLevel - 1);
      end else begin
         sh = 2'(lv - 3'd1);
      end
      return rx_time(lv) << sh;
   endfunction

   // Wait before entry
   function automatic logic [DeltaW-1:0] wait_time(input logic [LevelW-1:0] lv);
      int unsigned t;
      t = (WaitBase - WaitStep * int'(lv)) * WaitScale;
      return DeltaW'(t);
   endfunction

endpackage

// File: design/rxdc_step.sv
// Next-phase, deadline and response logic for one item.
// Depends on rxdc_pkg.
module rxdc_step (
   input  rxdc_pkg::rxdc_req_type   item,
   input  rxdc_pkg::rxdc_cfg_type   cfg,
   input  rxdc_pkg::rxdc_state_type cur,
   output rxdc_pkg::rxdc_state_type nxt,
   output rxdc_pkg::rxdc_rsp_type   rsp
);
   import rxdc_pkg::*;

   logic [LevelW-1:0] lvl_sat;
   logic              wake;
   logic              due;
   logic              deep;
   logic [DeltaW-1:0] delta;
   logic [TimeW-1:0]  new_deadline;

   assign lvl_sat = (cfg.save_level > LevelMax) ? LevelMax : cfg.save_level;
   assign wake    = item.has_signal | item.scan_stepping | item.user_event;
   assign due     = (item.now_ticks >= cur.deadline) && (cfg.save_level != '0) &&
                    !item.melody_playing && !item.prompt_playing;
   assign deep    = cfg.save_level > 3'd1;

   // Pick the interval for the phase being entered, then one add
   always_comb begin
      case (cur.phase)
         PH_INACTIVE: delta = wait_time(lvl_sat);
         PH_RX_OFF:   delta = rx_time(lvl_sat);
         default:     delta = off_time(lvl_sat);
      endcase
   end
   assign new_deadline = item.now_ticks + TimeW'(delta);

   always_comb begin
      nxt = cur;
      rsp = '0;
      if (item.req_type == REQ_FORCE) begin
         if (cur.phase != item.new_phase) begin
            if (cur.phase == PH_RX_OFF) begin
               rsp.power_cmd = PC_UP_ALL;
               rsp.beep_fix  = 1'b1;
            end
            rsp.audio_if_reset = (item.new_phase == PH_INACTIVE);
            nxt.phase = item.new_phase;
         end
      end else if (!cfg.hotspot_mode || cur.phase != PH_INACTIVE) begin
         if (wake) begin
            if (cur.phase != PH_INACTIVE) begin
               if (cur.phase == PH_RX_OFF) begin
                  rsp.power_cmd = PC_UP_ALL;
               end
               rsp.beep_fix = 1'b1;
               nxt.phase    = PH_INACTIVE;
            end
         end else if (due) begin
            nxt.deadline = new_deadline;
            unique case (cur.phase) inside
               PH_INACTIVE: begin
                  nxt.phase = PH_ENTRY;
               end
               PH_ENTRY, PH_RX_ON: begin
                  rsp.audio_if_disable = (cur.phase == PH_ENTRY) && deep;
                  rsp.power_cmd        = deep ? PC_DOWN_RX_BB : PC_DOWN_RX;
                  nxt.phase            = PH_RX_OFF;
               end
               default: begin
                  rsp.power_cmd = PC_UP_ALL;
                  nxt.phase     = PH_RX_ON;
               end
            endcase
         end
      end
      rsp.rx_on = (nxt.phase != PH_RX_OFF);
      rsp.phase = nxt.phase;
   end

endmodule

// File: design/rxdc_out_stage.sv
// Result register with valid/stall handshake towards the consumer.
// Depends on rxdc_pkg.
module rxdc_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  rxdc_pkg::rxdc_rsp_type load_data,
   output logic                   ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rxdc_pkg::rxdc_rsp_type rsp_data
);
   import rxdc_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rxdc_rsp_type data_ff;
   rxdc_rsp_type data_in;

   // Free when empty or when the held item leaves this cycle
   assign ready    = !valid_ff || !rsp_stall;
   assign valid_in = load ? 1'b1 : (valid_ff && rsp_stall);
   assign data_in  = load ? load_data : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: design/rx_duty_cycle_power_saver_unit.sv
// Top level of the receiver duty-cycle power saver.
// Depends on rxdc_pkg, rxdc_step, rxdc_out_stage and the assertion header.
//
//   port group | direction | handshake          | payload
//   req_       | in        | req_valid/req_stall | rxdc_req_type
//   rsp_       | out       | rsp_valid/rsp_stall | rxdc_rsp_type
//   csr_       | in        | csr_write_en        | csr_index, csr_wdata
//
// An item taken into the input register moves into the result register once that register
// can take it, and can leave from there at the next result handshake. One item is taken
// per cycle while req_stall is low.
// The phase and deadline registers are read and updated as an item moves
// from the input register into the result register, so items chain freely.
// Reset clears both stages, sets the phase to inactive, the deadline to zero,
// the save level to one and hotspot mode off. A stall on rsp_ only backs up
// into req_stall once both stages hold an item.
`include "rx_duty_cycle_power_saver_unit_assert.svh"
module rx_duty_cycle_power_saver_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rxdc_pkg::rxdc_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rxdc_pkg::rxdc_rsp_type rsp_data,
   input  logic                   csr_write_en,
   input  logic                   csr_index,
   input  logic [rxdc_pkg::LevelW-1:0] csr_wdata
);
   import rxdc_pkg::*;

   // Input register
   logic           in_valid_ff;
   logic           in_valid_in;
   rxdc_req_type   in_data_ff;
   rxdc_req_type   in_data_in;

   // Block state and configuration
   rxdc_state_type state_ff;
   rxdc_state_type state_in;
   rxdc_cfg_type   cfg_ff;
   rxdc_cfg_type   cfg_in;

   rxdc_state_type step_state;
   rxdc_rsp_type   step_rsp;
   logic           out_ready;
   logic           advance;

   // Move the held item on when the result register can take it
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;

   // Load a fresh item whenever not stalled; hold otherwise
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;
   assign in_data_in  = req_stall ? in_data_ff : req_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
   end

   rxdc_step u_step (
      .item (in_data_ff),
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .nxt  (step_state),
      .rsp  (step_rsp)
   );

   // Commit phase and deadline only as the item leaves for the result register
   assign state_in = advance ? step_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase    <= PH_INACTIVE;
         state_ff.deadline <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // Register writes; the user must send these only while the block is idle, it does not enforce it
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_SAVE_LEVEL:   cfg_in.save_level   = csr_wdata;
            CSR_HOTSPOT_MODE: cfg_in.hotspot_mode = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.save_level   <= LevelReset;
         cfg_ff.hotspot_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rxdc_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_data (step_rsp),
      .ready     (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `RXDC_ASSERT(a_rx_on_matches_phase, clock, reset, rsp_valid |-> (rsp_data.rx_on == (rsp_data.phase != PH_RX_OFF)), "rx_on disagrees with phase")
   `RXDC_ASSERT(a_state_tracks_result, clock, reset, advance |=> (state_ff.phase == rsp_data.phase), "stored phase differs from last result")
   `RXDC_ASSERT_ALWAYS(a_stall_only_when_full, clock, req_stall |-> in_valid_ff, "stall raised with empty input register")
   `RXDC_ASSERT(a_beep_not_off, clock, reset, (rsp_valid && rsp_data.beep_fix) |-> (rsp_data.phase != PH_RX_OFF), "beep fix requested while staying off")

endmodule
